### rtl/fbd_pkg.sv
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared types, constants and ring pointer helpers for the fault burst
// detector.
// ----------------------------------------------------------------------------
package fbd_pkg;

    localparam int RING_SLOTS = 16;
    localparam int PTR_W      = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int CNT_W      = 4;
    localparam int WIN_W      = 31;
    localparam int STAMP_W    = 32;
    localparam int CFG_W      = 31;
    localparam int IDX_W      = 3;
    localparam int MODE_W     = 2;
    localparam int PRES_W     = 3;
    localparam int NUM_CLS    = 3;
    localparam int SIZE_W     = ($clog2(RING_SLOTS + 1) > CNT_W + 1) ?
                                $clog2(RING_SLOTS + 1) : CNT_W + 1;

    typedef logic [1:0]         cls_t;
    typedef logic [IDX_W-1:0]   reg_idx_t;
    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [WIN_W-1:0]   win_t;
    typedef logic [STAMP_W-1:0] stamp_t;
    typedef logic [SIZE_W-1:0]  size_t;

    localparam cls_t CLS_GPU   = 2'd0;
    localparam cls_t CLS_PAGE  = 2'd1;
    localparam cls_t CLS_AICL  = 2'd2;
    localparam cls_t CLS_OTHER = 2'd3;

    localparam reg_idx_t REG_MODE      = 3'd0;
    localparam reg_idx_t REG_PRESENT   = 3'd1;
    localparam reg_idx_t REG_GPU_CNT   = 3'd2;
    localparam reg_idx_t REG_GPU_WIN   = 3'd3;
    localparam reg_idx_t REG_PAGE_CNT  = 3'd4;
    localparam reg_idx_t REG_PAGE_WIN  = 3'd5;
    localparam reg_idx_t REG_AICL_CNT  = 3'd6;
    localparam reg_idx_t REG_AICL_WIN  = 3'd7;

    typedef struct packed {
        cls_t   cls;
        logic   info;
        stamp_t stamp;
        logic   mirror;
        logic   err;
        logic   drop;
        cnt_t   level;
    } evt_t;

    function automatic size_t ring_size(cnt_t thr);
        size_t s;
        s = size_t'(thr) + size_t'(1);
        if (s > size_t'(RING_SLOTS)) begin
            s = size_t'(RING_SLOTS);
        end
        return s;
    endfunction

    function automatic ptr_t ring_adv(ptr_t p, size_t size);
        size_t n;
        n = size_t'(p) + size_t'(1);
        return (n >= size) ? '0 : ptr_t'(n);
    endfunction

endpackage

### rtl/fbd_cell.sv
// ----------------------------------------------------------------------------
// fbd_cell
// One class cell: stamp ring, head/tail pointers and failure count of one
// event class, with a word register handing events on to the next cell.
// ----------------------------------------------------------------------------
module fbd_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  fbd_pkg::cls_t  cell_id,
    input  logic           clr,
    input  fbd_pkg::cnt_t  thr,
    input  fbd_pkg::win_t  win,
    input  logic           in_valid,
    output logic           in_ready,
    input  fbd_pkg::evt_t  in_evt,
    output logic           out_valid,
    input  logic           out_ready,
    output fbd_pkg::evt_t  out_evt
);
    import fbd_pkg::*;

    stamp_t ring_reg [RING_SLOTS];
    ptr_t   head_reg, head_next;
    ptr_t   tail_reg, tail_next;
    cnt_t   cnt_reg;
    stamp_t newest_reg;
    logic   newest_ok_reg;
    logic   out_valid_reg;
    evt_t   out_evt_reg, out_evt_next;

    logic   take, mine, upd;
    size_t  size;
    ptr_t   nt, old_idx, head_adv;
    logic   drop, store, hit, err, full, aicl;
    stamp_t old_val, new_val, span;
    cnt_t   c_inc, c_res;

    assign in_ready  = !out_valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign mine      = (in_evt.cls == cell_id);
    assign upd       = take && mine && !in_evt.info;
    assign aicl      = (cell_id == CLS_AICL);
    assign out_valid = out_valid_reg;
    assign out_evt   = out_evt_reg;

    always_comb begin
        size      = ring_size(thr);
        c_inc     = cnt_reg + cnt_t'(1);
        nt        = ring_adv(tail_reg, size);
        drop      = (nt == head_reg);
        store     = !drop;
        tail_next = store ? nt : tail_reg;
        old_idx   = ring_adv(head_reg, size);
        // same-cycle forward of the stamp being stored
        old_val   = (store && old_idx == nt) ? in_evt.stamp : ring_reg[old_idx];
        new_val   = store ? in_evt.stamp : (newest_ok_reg ? newest_reg : old_val);
        span      = new_val - old_val;
        hit       = span < stamp_t'(win);
        head_adv  = (head_reg != tail_next) ? ring_adv(head_reg, size) : head_reg;
        full      = (ring_adv(tail_next, size) == head_reg);

        priority if (c_inc >= thr && !aicl) begin
            err       = hit;
            c_res     = '0;
            head_next = head_adv;
        end else if (c_inc >= thr && hit) begin
            err       = 1'b1;
            c_res     = '0;
            head_next = tail_next;
        end else if (c_inc >= thr) begin
            err       = 1'b0;
            c_res     = cnt_reg;
            head_next = head_adv;
        end else if (!aicl && full) begin
            err       = hit;
            c_res     = c_inc;
            head_next = head_adv;
        end else begin
            err       = 1'b0;
            c_res     = c_inc;
            head_next = head_reg;
        end

        out_evt_next = in_evt;
        if (mine) begin
            if (in_evt.info) begin
                out_evt_next.level = cnt_reg;
            end else begin
                out_evt_next.err   = err;
                out_evt_next.drop  = drop;
                out_evt_next.level = c_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            newest_ok_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (clr) begin
                head_reg      <= '0;
                tail_reg      <= '0;
                cnt_reg       <= '0;
                newest_ok_reg <= 1'b0;
            end else if (upd) begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                cnt_reg  <= c_res;
                if (store) begin
                    newest_ok_reg <= 1'b1;
                end
            end
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_evt_reg <= out_evt_next;
        end
        if (upd && store) begin
            ring_reg[nt] <= in_evt.stamp;
            newest_reg   <= in_evt.stamp;
        end
    end

endmodule

### rtl/fault_burst_detector.sv
// ----------------------------------------------------------------------------
// fault_burst_detector
// Sliding-window burst detector for fault events: a row of three class cells
// (gpu, gpu page, aicl) through which every event word passes in order.
// Each cell registers the word on its way from input to result.
// Throughput: one word per cycle while m_ready holds; each cell updates its
// class state as it takes a word, so back-to-back words of one class chain.
// Reset clears pointers, counts, config and valids; ring stamps are not reset.
// Writing report_mode zero clears all pointers and counts of every cell.
// ----------------------------------------------------------------------------
module fault_burst_detector (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_cmd,
    input  logic                      s_is_info,
    input  logic [31:0]               s_stamp,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_mirror_report,
    output logic                      m_error_report,
    output logic                      m_ring_dropped,
    output logic [3:0]                m_fail_level,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [fbd_pkg::IDX_W-1:0] cfg_index,
    input  logic [fbd_pkg::CFG_W-1:0] cfg_data
);
    import fbd_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [PRES_W-1:0] present_reg;
    cnt_t              thr_reg [NUM_CLS];
    win_t              win_reg [NUM_CLS];

    logic              en, counted, clr;
    logic [3:0]        present_ext;
    evt_t              stage_evt   [NUM_CLS+1];
    logic              stage_valid [NUM_CLS+1];
    logic              stage_ready [NUM_CLS+1];

    assign cfg_ready   = 1'b1;
    assign clr         = cfg_valid && (cfg_index == REG_MODE) &&
                         (cfg_data[MODE_W-1:0] == '0);
    assign en          = (mode_reg != '0);
    assign present_ext = {1'b0, present_reg};
    assign counted     = (s_cmd != CLS_OTHER) && present_ext[s_cmd];

    always_comb begin
        stage_evt[0].cls    = (en && counted) ? s_cmd : CLS_OTHER;
        stage_evt[0].info   = s_is_info;
        stage_evt[0].stamp  = s_stamp;
        stage_evt[0].mirror = en && mode_reg[1];
        stage_evt[0].err    = en && !s_is_info && !counted;
        stage_evt[0].drop   = 1'b0;
        stage_evt[0].level  = '0;
    end

    assign stage_valid[0]       = s_valid;
    assign s_ready              = stage_ready[0];
    assign stage_ready[NUM_CLS] = m_ready;

    assign m_valid         = stage_valid[NUM_CLS];
    assign m_mirror_report = stage_evt[NUM_CLS].mirror;
    assign m_error_report  = stage_evt[NUM_CLS].err;
    assign m_ring_dropped  = stage_evt[NUM_CLS].drop;
    assign m_fail_level    = stage_evt[NUM_CLS].level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= '0;
            present_reg <= '0;
            for (int k = 0; k < NUM_CLS; k++) begin
                thr_reg[k] <= '0;
                win_reg[k] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MODE:     mode_reg          <= cfg_data[MODE_W-1:0];
                REG_PRESENT:  present_reg       <= cfg_data[PRES_W-1:0];
                REG_GPU_CNT:  thr_reg[CLS_GPU]  <= cfg_data[CNT_W-1:0];
                REG_GPU_WIN:  win_reg[CLS_GPU]  <= cfg_data[WIN_W-1:0];
                REG_PAGE_CNT: thr_reg[CLS_PAGE] <= cfg_data[CNT_W-1:0];
                REG_PAGE_WIN: win_reg[CLS_PAGE] <= cfg_data[WIN_W-1:0];
                REG_AICL_CNT: thr_reg[CLS_AICL] <= cfg_data[CNT_W-1:0];
                REG_AICL_WIN: win_reg[CLS_AICL] <= cfg_data[WIN_W-1:0];
            endcase
        end
    end

    for (genvar k = 0; k < NUM_CLS; k++) begin : g_cell
        fbd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_id   (cls_t'(k)),
            .clr       (clr),
            .thr       (thr_reg[k]),
            .win       (win_reg[k]),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_evt    (stage_evt[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_evt   (stage_evt[k+1])
        );
    end

    a_stall_needs_word: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> stage_valid[1])
        else $error("input stalled with first cell empty");

    a_word_moves_on: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_valid[1] && stage_ready[1] |=> stage_valid[2])
        else $error("word leaving first cell was lost");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

endmodule
